/* design/pcxd_pkg.sv */
// pcxd_pkg: shared types and constants for the PCX run-length palette decoder.
// Used by pcxd_front, pcxd_queue, pcxd_back and pcx_rle_palette_decoder.
`default_nettype none

package pcxd_pkg;

	localparam int MAX_COLUMNS     = 320;
	localparam int MAX_ROWS        = 256;
	localparam int PALETTE_ENTRIES = 256;
	localparam int QUEUE_DEPTH     = 4;

	localparam int COL_W   = 9;
	localparam int ROW_W   = 9;
	localparam int LROW_W  = 8;
	localparam int RUN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int RGB_W   = 24;
	localparam int CAP_W   = 13;
	localparam int CFG_W   = 9;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int PAL_A_W = $clog2(PALETTE_ENTRIES);

	localparam logic [CAP_W-1:0] COL_CAP = CAP_W'(MAX_COLUMNS - 1);
	localparam logic [CAP_W-1:0] ROW_CAP = CAP_W'(MAX_ROWS - 1);

	localparam logic [1:0]        RUN_MARK = 2'b11;
	localparam logic [BYTE_W-1:0] OPAQUE   = 8'd255;

	typedef enum logic [1:0] {
		OP_PALETTE = 2'd0,
		OP_START   = 2'd1,
		OP_DATA    = 2'd2
	} op_t;

	typedef enum logic {
		REG_LAST_COLUMN = 1'b0,
		REG_LAST_ROW    = 1'b1
	} reg_idx_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EMIT = 1'b1
	} back_state_t;

	typedef struct packed {
		logic               is_write;
		logic [BYTE_W-1:0]  index;
		logic [RGB_W-1:0]   rgb;
		logic [RUN_W-1:0]   run;
		logic               completes;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

/* design/pcx_rle_palette_decoder.sv */
// pcx_rle_palette_decoder: top level of the PCX 8-bit run-length palette decoder.
// Instantiates pcxd_front, pcxd_queue and pcxd_back; depends on pcxd_pkg.
//
//   port group      handshake                    content
//   input request   in_valid / in_ready          operation, data_byte, palette entry
//   pixel result    out_valid / out_ready        red, green, blue, alpha, flags
//   configuration   write_enable (no wait)       register_index, write_data
//
// The front takes one request per cycle while the four-entry command queue has room.
// The back applies each palette write when popped; for each literal or run it reads
// the color table once, then emits its pixels, each held until out_ready takes it.
// A stalled output holds the back; the queue then fills and in_ready drops.
// Reset clears counters, flags and the queue; the color table is not cleared.
`default_nettype none

module pcx_rle_palette_decoder (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [1:0]                   operation,
	input  wire  [7:0]                   data_byte,
	input  wire  [7:0]                   palette_index,
	input  wire  [7:0]                   entry_red,
	input  wire  [7:0]                   entry_green,
	input  wire  [7:0]                   entry_blue,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic [7:0]                   alpha,
	output logic                         last_of_run,
	output logic                         image_complete,
	input  wire                          write_enable,
	input  wire                          register_index,
	input  wire  [pcxd_pkg::CFG_W-1:0]   write_data
);
	import pcxd_pkg::*;

	push_t  push;
	qstat_t qstat;
	cmd_t   head;
	logic   pop;

	pcxd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.palette_index  (palette_index),
		.entry_red      (entry_red),
		.entry_green    (entry_green),
		.entry_blue     (entry_blue),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.qstat          (qstat),
		.push           (push)
	);

	pcxd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	pcxd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.qstat          (qstat),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.alpha          (alpha),
		.last_of_run    (last_of_run),
		.image_complete (image_complete)
	);

endmodule

`default_nettype wire

/* design/pcxd_front.sv */
// pcxd_front: accepts input items, holds geometry registers and position state,
// and turns palette and data items into write or run commands. Depends on pcxd_pkg.
`default_nettype none

module pcxd_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [1:0]            operation,
	input  wire  [7:0]            data_byte,
	input  wire  [7:0]            palette_index,
	input  wire  [7:0]            entry_red,
	input  wire  [7:0]            entry_green,
	input  wire  [7:0]            entry_blue,
	input  wire                   write_enable,
	input  wire                   register_index,
	input  wire  [pcxd_pkg::CFG_W-1:0] write_data,
	input  pcxd_pkg::qstat_t      qstat,
	output pcxd_pkg::push_t       push
);
	import pcxd_pkg::*;

	logic [COL_W-1:0]  last_column_q;
	logic [LROW_W-1:0] last_row_q;
	logic [COL_W-1:0]  col_q, col_n;
	logic [ROW_W-1:0]  row_q, row_n;
	logic [RUN_W-1:0]  held_q, held_n;
	logic              await_q, await_n;
	logic              fin_q, fin_n;

	logic              accept;
	logic [COL_W-1:0]  clim;
	logic [LROW_W-1:0] rlim;
	logic              s_wrap;
	logic [COL_W-1:0]  s_col;
	logic [ROW_W-1:0]  s_row;
	logic              s_fin;
	logic              go;
	logic [RUN_W-1:0]  run;
	logic              on_last;
	logic [COL_W:0]    sum;
	logic [COL_W:0]    lim1;
	logic              clipped;
	logic [COL_W:0]    end_col;
	logic [ROW_W-1:0]  row_inc;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_column_q <= COL_W'(319);
			last_row_q    <= LROW_W'(199);
		end else if (write_enable) begin
			unique case (reg_idx_t'(register_index))
				REG_LAST_COLUMN: last_column_q <= write_data;
				REG_LAST_ROW:    last_row_q    <= write_data[LROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		clim    = ({{(CAP_W-COL_W){1'b0}}, last_column_q} < COL_CAP) ?
			last_column_q : COL_CAP[COL_W-1:0];
		rlim    = ({{(CAP_W-LROW_W){1'b0}}, last_row_q} < ROW_CAP) ?
			last_row_q : ROW_CAP[LROW_W-1:0];
		s_wrap  = col_q > clim;
		s_col   = s_wrap ? '0 : col_q;
		s_row   = s_wrap ? row_q + ROW_W'(1) : row_q;
		s_fin   = s_row > {1'b0, rlim};

		go  = 1'b0;
		run = RUN_W'(1);
		if (await_q)
			run = held_q;

		on_last = s_row == {1'b0, rlim};
		sum     = {1'b0, s_col} + {{(COL_W+1-RUN_W){1'b0}}, run};
		lim1    = {1'b0, clim} + (COL_W+1)'(1);
		clipped = on_last && (sum > lim1);
		end_col = clipped ? lim1 : sum;
		row_inc = s_row + ROW_W'(1);

		col_n   = col_q;
		row_n   = row_q;
		held_n  = held_q;
		await_n = await_q;
		fin_n   = fin_q;
		push    = '0;

		if (accept) begin
			unique case (op_t'(operation))
				OP_PALETTE: begin
					push.push          = 1'b1;
					push.cmd.is_write  = 1'b1;
					push.cmd.index     = palette_index;
					push.cmd.rgb       = {entry_red, entry_green, entry_blue};
				end
				OP_START: begin
					col_n   = '0;
					row_n   = '0;
					held_n  = '0;
					await_n = 1'b0;
					fin_n   = 1'b0;
				end
				OP_DATA: begin
					if (!fin_q) begin
						col_n = s_col;
						row_n = s_row;
						fin_n = s_fin;
						if (!s_fin) begin
							if (await_q) begin
								go      = 1'b1;
								await_n = 1'b0;
								held_n  = '0;
							end else if (data_byte[7:6] == RUN_MARK) begin
								held_n  = data_byte[RUN_W-1:0];
								await_n = 1'b1;
							end else begin
								go = 1'b1;
							end
							if (go && run != '0) begin
								push.push          = 1'b1;
								push.cmd.index     = data_byte;
								push.cmd.run       = clipped ?
									RUN_W'(lim1 - {1'b0, s_col}) : run;
								push.cmd.completes = on_last && (end_col == lim1);
								if (end_col > {1'b0, clim}) begin
									col_n = '0;
									row_n = row_inc;
									fin_n = row_inc > {1'b0, rlim};
								end else begin
									col_n = end_col[COL_W-1:0];
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			held_q  <= '0;
			await_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			col_q   <= col_n;
			row_q   <= row_n;
			held_q  <= held_n;
			await_q <= await_n;
			fin_q   <= fin_n;
		end
	end

endmodule

`default_nettype wire

/* design/pcxd_queue.sv */
// pcxd_queue: short command queue between front and back of the decoder.
// Depends on pcxd_pkg for the command type and depth.
`default_nettype none

module pcxd_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  pcxd_pkg::push_t    push,
	input  wire                pop,
	output pcxd_pkg::cmd_t     head,
	output pcxd_pkg::qstat_t   qstat
);
	import pcxd_pkg::*;

	cmd_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QPTR_W:0]    count_q;

	assign head        = slot_q[rptr_q];
	assign qstat.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push.push)
			slot_q[wptr_q] <= push.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (push.push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push.push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

`default_nettype wire

/* design/pcxd_back.sv */
// pcxd_back: owns the color table, applies palette writes in order and emits
// one RGBA pixel per cycle of a run unless stalled. Depends on pcxd_pkg.
`default_nettype none

module pcxd_back (
	input  wire                clk,
	input  wire                arst_n,
	input  pcxd_pkg::cmd_t     head,
	input  pcxd_pkg::qstat_t   qstat,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         alpha,
	output logic               last_of_run,
	output logic               image_complete
);
	import pcxd_pkg::*;

	logic [RGB_W-1:0]  color_table [PALETTE_ENTRIES];
	logic [RGB_W-1:0]  rgb_q;
	logic [RUN_W-1:0]  remain_q;
	logic              comp_q;
	back_state_t       state_q, state_n;
	logic              take;
	logic              final_px;

	assign take     = out_valid && out_ready;
	assign final_px = remain_q == RUN_W'(1);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty && !head.is_write)
					state_n = BK_EMIT;
			end
			BK_EMIT: begin
				if (take && final_px)
					state_n = BK_IDLE;
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop            = 1'b0;
		out_valid      = 1'b0;
		unique case (state_q)
			BK_IDLE: pop       = !qstat.empty;
			BK_EMIT: out_valid = 1'b1;
			default: ;
		endcase
		red            = rgb_q[23:16];
		green          = rgb_q[15:8];
		blue           = rgb_q[7:0];
		alpha          = OPAQUE;
		last_of_run    = final_px;
		image_complete = comp_q && final_px;
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_write)
			color_table[head.index[PAL_A_W-1:0]] <= head.rgb;
		if (pop && !head.is_write)
			rgb_q <= color_table[head.index[PAL_A_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			remain_q <= '0;
			comp_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (pop && !head.is_write) begin
				remain_q <= head.run;
				comp_q   <= head.completes;
			end else if (take) begin
				remain_q <= remain_q - RUN_W'(1);
			end
		end
	end

endmodule

`default_nettype wire
